>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the panel RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge outside reset.
`define KMLP_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("kmlp: invariant violated");

// Antecedent implies consequent in the same cycle.
`define KMLP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kmlp: same-cycle implication violated");

// Antecedent implies consequent in the next cycle.
`define KMLP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kmlp: next-cycle implication violated");

`endif

>>> hw/rtl/kmlp_pkg.sv
// Types and constants for the key menu LED panel.
`default_nettype none

package kmlp_pkg;

  // Menu phase, one-hot
  typedef enum logic [2:0] {
    PH_TASK  = 3'b001,
    PH_SPEED = 3'b010,
    PH_RUN   = 3'b100
  } phase_t;

  // Which key is held latched, one-hot (none is all zero)
  typedef enum logic [1:0] {
    LATCH_NONE = 2'b00,
    LATCH_ONE  = 2'b01,
    LATCH_TWO  = 2'b10
  } latch_t;

  // Reported menu_state codes
  localparam logic [1:0] STATE_TASK  = 2'd0;
  localparam logic [1:0] STATE_SPEED = 2'd1;
  localparam logic [1:0] STATE_RUN   = 2'd2;

  localparam logic [2:0] TASK_NONE   = 3'd0;
  localparam logic [2:0] TASK_FIRST  = 3'd1;
  localparam logic [2:0] TASK_MAX    = 3'd4;
  localparam logic [6:0] SPEED_MIN   = 7'd30;
  localparam logic [6:0] SPEED_MAX   = 7'd100;
  localparam logic [6:0] SPEED_STEP  = 7'd10;
  localparam logic [4:0] LED_ALL_OFF = 5'h1F;
  localparam logic [3:0] LIMIT_RESET = 4'd4;

  typedef struct packed {
    logic key_one_low;
    logic key_two_low;
    logic round_zone;
  } in_word_t;

  typedef struct packed {
    logic [4:0] led_levels;
    logic       mode_led_level;
    logic [2:0] task_now;
    logic [6:0] speed_now;
    logic [1:0] menu_state;
  } out_word_t;

  // Key side state
  typedef struct packed {
    phase_t     phase;
    logic [2:0] task_sel;
    logic [6:0] speed_sel;
    latch_t     latch;
    logic [3:0] press_count;
  } key_state_t;

  // LED side state
  typedef struct packed {
    logic [4:0] bank;
    logic       mode;
    logic [2:0] shown_task;
    logic [6:0] shown_speed;
    logic [3:0] speed_code;
  } led_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/key_menu_led_panel.sv
// Top level of the two-button key menu LED panel.
//
// Input channel in_valid/in_ready/in_data carries one scan tick per word:
// both key levels (1 = pressed) and the round indicator. Output channel
// out_valid/out_ready/out_data returns one word per tick: LED pin levels
// (active low), mode LED, task, speed and menu state after that tick.
// A word accepted at an edge is shown on out_data from that edge on.
// Throughput is one word per cycle while the receiver does not stall, set
// by the single state register stage that holds the key and LED state.
// The debounce limit is written through debounce_limit_we and
// debounce_limit_wdata, with no handshake; write it only while idle.
// Reset (rst, synchronous) returns the menu to task setting, speed 30,
// all LEDs off, debounce limit 4, and empties the output register.
// When the receiver stalls, the output word holds; in_ready stays high
// only while the output register is empty or being drained this cycle.
`default_nettype none
`include "assert_macros.svh"

module key_menu_led_panel
  import kmlp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data,
  input  logic       debounce_limit_we,
  input  logic [3:0] debounce_limit_wdata
);

  key_state_t key_q;
  key_state_t key_next;
  led_state_t led_q;
  led_state_t led_next;
  logic [3:0] limit;
  logic       take;
  logic [1:0] state_code;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  kmlp_keys u_keys (
    .cur   (key_q),
    .word  (in_data),
    .limit (limit),
    .nxt   (key_next)
  );

  kmlp_leds u_leds (
    .keys       (key_next),
    .cur        (led_q),
    .round_zone (in_data.round_zone),
    .nxt        (led_next)
  );

  // phase to reported code
  always_comb begin
    unique case (key_next.phase)
      PH_TASK:  state_code = STATE_TASK;
      PH_SPEED: state_code = STATE_SPEED;
      PH_RUN:   state_code = STATE_RUN;
      default:  state_code = STATE_TASK;
    endcase
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (debounce_limit_we) begin
      limit <= debounce_limit_wdata;
    end
  end

  // panel state
  always_ff @(posedge clk) begin
    if (rst) begin
      key_q.phase       <= PH_TASK;
      key_q.task_sel    <= TASK_NONE;
      key_q.speed_sel   <= SPEED_MIN;
      key_q.latch       <= LATCH_NONE;
      key_q.press_count <= 4'd0;
      led_q.bank        <= LED_ALL_OFF;
      led_q.mode        <= 1'b1;
      led_q.shown_task  <= TASK_NONE;
      led_q.shown_speed <= 7'd0;
      led_q.speed_code  <= 4'd0;
    end else if (take) begin
      key_q <= key_next;
      led_q <= led_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.led_levels     <= led_next.bank;
      out_data.mode_led_level <= led_next.mode;
      out_data.task_now       <= key_next.task_sel;
      out_data.speed_now      <= key_next.speed_sel;
      out_data.menu_state     <= state_code;
    end
  end

  `KMLP_ASSERT_NEXT(a_take_gives_word, take, out_valid)
  `KMLP_ASSERT_NEXT(a_run_is_final, key_q.phase == PH_RUN, key_q.phase == PH_RUN)
  `KMLP_ASSERT_ALWAYS(a_task_range, key_q.task_sel <= TASK_MAX)
  `KMLP_ASSERT_IMPL(a_task_phase_no_code, key_q.phase == PH_TASK, led_q.speed_code == 4'd0)

endmodule

`default_nettype wire

>>> hw/rtl/kmlp_keys.sv
// Key scan: debounce, latch and menu selection update for one tick.
`default_nettype none

module kmlp_keys
  import kmlp_pkg::*;
(
  input  key_state_t cur,
  input  in_word_t   word,
  input  logic [3:0] limit,
  output key_state_t nxt
);

  logic [4:0] cnt_inc;
  logic       hit;
  logic [7:0] speed_sum;

  assign cnt_inc   = {1'b0, cur.press_count} + 5'd1;
  assign hit       = cnt_inc > {1'b0, limit};
  assign speed_sum = {1'b0, cur.speed_sel} + {1'b0, SPEED_STEP};

  // Key one first, then key two, release only with both keys up
  always_comb begin
    nxt = cur;
    if (cur.phase != PH_RUN) begin
      priority if (word.key_one_low && cur.latch != LATCH_ONE) begin
        nxt.press_count = hit ? 4'd0 : cnt_inc[3:0];
        if (hit) begin
          nxt.latch = LATCH_ONE;
          if (cur.phase == PH_TASK) begin
            nxt.task_sel = (cur.task_sel >= TASK_MAX) ? TASK_FIRST
                                                      : cur.task_sel + 3'd1;
          end else if (cur.phase == PH_SPEED) begin
            nxt.speed_sel = (speed_sum > {1'b0, SPEED_MAX}) ? SPEED_MIN
                                                            : speed_sum[6:0];
          end
        end
      end else if (word.key_two_low && cur.latch != LATCH_TWO) begin
        nxt.press_count = hit ? 4'd0 : cnt_inc[3:0];
        if (hit) begin
          nxt.latch = LATCH_TWO;
          unique case (cur.phase)
            PH_TASK:  nxt.phase = PH_SPEED;
            PH_SPEED: nxt.phase = PH_RUN;
            default:  nxt.phase = PH_TASK;
          endcase
        end
      end else if (!word.key_one_low && !word.key_two_low) begin
        nxt.latch       = LATCH_NONE;
        nxt.press_count = 4'd0;
      end else begin
        // held key stays latched, nothing changes
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/kmlp_leds.sv
// LED update: task one-hot, speed code, and run-phase round indicator.
`default_nettype none

module kmlp_leds
  import kmlp_pkg::*;
(
  input  key_state_t keys,
  input  led_state_t cur,
  input  logic       round_zone,
  output led_state_t nxt
);

  // speed/10 - 2, four bits
  function automatic logic [3:0] speed_code_of(input logic [6:0] s);
    logic [3:0] c;
    c = 4'd0;
    priority if (s >= 7'd120) c = 4'd10;
    else if (s >= 7'd110) c = 4'd9;
    else if (s >= 7'd100) c = 4'd8;
    else if (s >= 7'd90)  c = 4'd7;
    else if (s >= 7'd80)  c = 4'd6;
    else if (s >= 7'd70)  c = 4'd5;
    else if (s >= 7'd60)  c = 4'd4;
    else if (s >= 7'd50)  c = 4'd3;
    else if (s >= 7'd40)  c = 4'd2;
    else if (s >= 7'd30)  c = 4'd1;
    else c = 4'd0;
    return c;
  endfunction

  logic [3:0] code;
  logic [4:0] task_mask;

  assign code      = speed_code_of(keys.speed_sel);
  assign task_mask = 5'd1 << keys.task_sel;

  // Per-phase LED behavior, driven by the post-scan selection
  always_comb begin
    nxt = cur;
    unique case (keys.phase)
      PH_TASK: begin
        nxt.mode = 1'b1;
        if (cur.shown_task != keys.task_sel) nxt.bank = LED_ALL_OFF;
        nxt.shown_task = keys.task_sel;
        if (keys.task_sel >= TASK_FIRST && keys.task_sel <= TASK_MAX) begin
          nxt.bank = nxt.bank & ~task_mask;
        end
      end
      PH_SPEED: begin
        nxt.mode = 1'b0;
        if (cur.shown_speed != keys.speed_sel) nxt.bank = LED_ALL_OFF;
        nxt.shown_speed = keys.speed_sel;
        nxt.speed_code  = code;
        // codes 1..7 in binary on LEDs 1..3, code 8 on LED 4
        if (code >= 4'd1 && code <= 4'd7) begin
          nxt.bank = nxt.bank & ~{1'b0, code[2:0], 1'b0};
        end else if (code == 4'd8) begin
          nxt.bank = nxt.bank & 5'b01111;
        end
      end
      PH_RUN: begin
        // first run tick clears the speed display
        if (cur.speed_code != 4'd0) begin
          nxt.mode       = 1'b1;
          nxt.bank       = LED_ALL_OFF;
          nxt.speed_code = 4'd0;
        end
        nxt.bank[0] = ~round_zone;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
